FILE: hdl/lkv_pkg.sv
// shared constants, codes and types for the linear key/value table
`timescale 1ns / 1ps
package lkv_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH      = 2;

   localparam int REQ_TYPE_W    = 2;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // decoded operation; neither bit set means lookup
   typedef struct packed {
      logic is_insert;
      logic is_remove;
   } op_type;

   localparam int OP_W = $bits(op_type);

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_SEARCH     = 5'b00010,
      ST_FETCH_LAST = 5'b00100,
      ST_DONE       = 5'b01000,
      ST_SPARE      = 5'b10000
   } back_state_type;

endpackage

FILE: hdl/lkv_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lkv_front.sv
// request intake: decodes the request code and trims the key
`timescale 1ns / 1ps
module lkv_front #(
   parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEFAULT
) (
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lkv_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [lkv_pkg::KEY_W-1:0]      req_key,
   input  logic [lkv_pkg::VALUE_W-1:0]    req_value,
   input  logic                           q_full,
   output logic                           q_push,
   output lkv_pkg::op_type                q_op,
   output logic [KEY_BITS-1:0]            q_key,
   output logic [lkv_pkg::VALUE_W-1:0]    q_value
);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign q_key     = KEY_BITS'(req_key);
   assign q_value   = req_value;

   // unused code 3 behaves as a lookup
   always_comb begin
      q_op = '0;
      unique case (req_type)
         lkv_pkg::REQ_INSERT: q_op.is_insert = 1'b1;
         lkv_pkg::REQ_REMOVE: q_op.is_remove = 1'b1;
         default: q_op = '0;
      endcase
   end

endmodule

FILE: hdl/lkv_queue.sv
// short fifo between request intake and the search engine
`timescale 1ns / 1ps
module lkv_queue #(
   parameter int WIDTH = 66
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = $clog2(lkv_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(lkv_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [lkv_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(lkv_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lkv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lkv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/lkv_back.sv
// search engine: scans the key store, updates the table, holds the response
`timescale 1ns / 1ps
module lkv_back #(
   parameter int DEPTH    = lkv_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_not_empty,
   output logic                              q_pop,
   input  lkv_pkg::op_type                   q_op,
   input  logic [KEY_BITS-1:0]               q_key,
   input  logic [lkv_pkg::VALUE_W-1:0]       q_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lkv_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lkv_pkg::VALUE_W-1:0]       rsp_value_out,
   output logic [lkv_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count,
   output logic                              rsp_is_empty
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   lkv_pkg::back_state_type state_ff, state_in;

   logic [ADDR_W-1:0]           idx_ff, idx_in;
   logic [ADDR_W-1:0]           pos_ff, pos_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   lkv_pkg::op_type             op_ff, op_in;
   logic [KEY_BITS-1:0]         key_ff, key_in;
   logic [lkv_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                        hit_ff, hit_in;
   logic [lkv_pkg::VALUE_W-1:0] found_ff, found_in;
   logic [KEY_BITS-1:0]         last_key_ff, last_key_in;
   logic [lkv_pkg::VALUE_W-1:0] last_val_ff, last_val_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lkv_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [lkv_pkg::VALUE_W-1:0] vout_ff, vout_in;
   logic                        load_rsp;

   logic [ADDR_W-1:0]           rd_addr;
   logic [KEY_BITS-1:0]         key_rd;
   logic [lkv_pkg::VALUE_W-1:0] val_rd;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [KEY_BITS-1:0]         wr_key;
   logic [lkv_pkg::VALUE_W-1:0] wr_val;

   logic [ADDR_W-1:0]           last_addr;
   logic                        out_free;
   logic                        is_full;
   logic                        match;

   assign last_addr = ADDR_W'(count_ff - 1'b1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign match     = (key_rd == key_ff);
   assign q_pop     = (state_ff == lkv_pkg::ST_IDLE) && q_not_empty;

   lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_key),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lkv_ram #(.WIDTH(lkv_pkg::VALUE_W), .DEPTH(DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_val),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      hit_in      = hit_ff;
      found_in    = found_ff;
      last_key_in = last_key_ff;
      last_val_in = last_val_ff;
      status_in   = status_ff;
      vout_in     = vout_ff;
      load_rsp    = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = ADDR_W'(count_ff);
      wr_key      = key_ff;
      wr_val      = value_ff;

      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               op_in    = q_op;
               key_in   = q_key;
               value_in = q_value;
               hit_in   = 1'b0;
               idx_in   = '0;
               // empty table: nothing to scan
               state_in = (count_ff == '0) ? lkv_pkg::ST_DONE : lkv_pkg::ST_SEARCH;
            end
         end
         lkv_pkg::ST_SEARCH: begin
            // read data here belongs to entry idx_ff
            if (match) begin
               hit_in   = 1'b1;
               pos_in   = idx_ff;
               found_in = val_rd;
               if (op_ff.is_remove) begin
                  rd_addr  = last_addr;
                  state_in = lkv_pkg::ST_FETCH_LAST;
               end else begin
                  state_in = lkv_pkg::ST_DONE;
               end
            end else if (idx_ff == last_addr) begin
               state_in = lkv_pkg::ST_DONE;
            end else begin
               rd_addr  = idx_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
            end
         end
         lkv_pkg::ST_FETCH_LAST: begin
            last_key_in = key_rd;
            last_val_in = val_rd;
            state_in    = lkv_pkg::ST_DONE;
         end
         lkv_pkg::ST_DONE: begin
            if (out_free) begin
               load_rsp  = 1'b1;
               state_in  = lkv_pkg::ST_IDLE;
               status_in = lkv_pkg::STATUS_OK;
               vout_in   = '0;
               if (op_ff.is_insert) begin
                  if (hit_ff) begin
                     status_in = lkv_pkg::STATUS_MISS;
                  end else if (is_full) begin
                     status_in = lkv_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else if (op_ff.is_remove) begin
                  if (hit_ff) begin
                     // last entry fills the freed slot
                     vout_in  = found_ff;
                     wr_en    = 1'b1;
                     wr_addr  = pos_ff;
                     wr_key   = last_key_ff;
                     wr_val   = last_val_ff;
                     count_in = count_ff - 1'b1;
                  end else begin
                     status_in = lkv_pkg::STATUS_MISS;
                  end
               end else begin
                  if (hit_ff) begin
                     vout_in = found_ff;
                  end else begin
                     status_in = lkv_pkg::STATUS_MISS;
                  end
               end
            end
         end
         default: begin
            state_in = lkv_pkg::ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      found_ff    <= found_in;
      last_key_ff <= last_key_in;
      last_val_ff <= last_val_in;
      status_ff   <= status_in;
      vout_ff     <= vout_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_value_out   = vout_ff;
   assign rsp_entry_count = lkv_pkg::ENTRY_COUNT_W'(count_ff);
   assign rsp_is_empty    = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lkv_pkg::ST_SEARCH) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index past the filled entries");

   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lkv_pkg::ST_DONE && !out_free) |=> (state_ff == lkv_pkg::ST_DONE))
      else $error("response finished while output still held");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && op_ff.is_insert && status_in == lkv_pkg::STATUS_OK)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the table");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && op_ff.is_remove && status_in == lkv_pkg::STATUS_OK)
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not shrink the table");

endmodule

FILE: hdl/linear_key_value_table_core.sv
// linear key/value table: request intake, queue and search engine
// a request passes through the intake queue, then the engine scans the stored keys, one per cycle;
// a remove that hits also fetches the last entry before the response is registered
// the engine takes a new request only after the response of the last one is loaded; the intake
// queue holds two requests meanwhile
// reset: synchronous, empties the table and queue; stores need no clearing pass
`timescale 1ns / 1ps
module linear_key_value_table_core #(
   parameter int DEPTH    = lkv_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lkv_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [lkv_pkg::KEY_W-1:0]         req_key,
   input  logic [lkv_pkg::VALUE_W-1:0]       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lkv_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lkv_pkg::VALUE_W-1:0]       rsp_value_out,
   output logic [lkv_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count,
   output logic                              rsp_is_empty
);

   localparam int Q_W = lkv_pkg::OP_W + KEY_BITS + lkv_pkg::VALUE_W;

   logic                        q_full, q_push, q_pop, q_not_empty;
   lkv_pkg::op_type             in_op, head_op;
   logic [KEY_BITS-1:0]         in_key, head_key;
   logic [lkv_pkg::VALUE_W-1:0] in_value, head_value;
   logic [Q_W-1:0]              head_data;

   lkv_front #(.KEY_BITS(KEY_BITS)) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_key   (req_key),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_op      (in_op),
      .q_key     (in_key),
      .q_value   (in_value)
   );

   lkv_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({in_op, in_key, in_value}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (head_data)
   );

   assign head_op    = lkv_pkg::op_type'(head_data[Q_W-1 -: lkv_pkg::OP_W]);
   assign head_key   = head_data[lkv_pkg::VALUE_W +: KEY_BITS];
   assign head_value = head_data[lkv_pkg::VALUE_W-1:0];

   lkv_back #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_pop           (q_pop),
      .q_op            (head_op),
      .q_key           (head_key),
      .q_value         (head_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

FILE: tb/tb_linear_key_value_table_core.sv
// testbench for the linear key/value table: directed and random requests checked by a scoreboard
`timescale 1ns / 1ps
package tb_lkv_scoreboard_pkg;
   import lkv_pkg::*;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   // code left over in the two request bits, behaves as a lookup
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [VALUE_W-1:0]       value;
      logic [ENTRY_COUNT_W-1:0] count;
      logic                     empty;
   } kv_result_t;

   class kv_table_scoreboard;
      logic [KEY_W-1:0]   keys [TABLE_DEPTH];
      logic [VALUE_W-1:0] vals [TABLE_DEPTH];
      int unsigned        fill;
      kv_result_t         awaited [$];
      int unsigned        errors;

      function new();
         fill = 0;
         errors = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // apply one accepted request to the shadow table and queue its response
      function void note_request(logic [REQ_TYPE_W-1:0] kind, logic [KEY_W-1:0] k,
                                 logic [VALUE_W-1:0] v);
         int pos;
         kv_result_t r;
         pos = -1;
         for (int i = 0; i < fill; i++)
            if (pos < 0 && keys[i] == k) pos = i;
         r.status = STATUS_OK;
         r.value = '0;
         case (kind)
            REQ_INSERT: begin
               if (pos >= 0) r.status = STATUS_MISS;
               else if (fill >= TABLE_DEPTH) r.status = STATUS_FULL;
               else begin
                  keys[fill] = k;
                  vals[fill] = v;
                  fill++;
               end
            end
            REQ_REMOVE: begin
               if (pos < 0) r.status = STATUS_MISS;
               else begin
                  // last entry fills the hole
                  r.value = vals[pos];
                  keys[pos] = keys[fill-1];
                  vals[pos] = vals[fill-1];
                  fill--;
               end
            end
            default: begin
               if (pos < 0) r.status = STATUS_MISS;
               else r.value = vals[pos];
            end
         endcase
         r.count = ENTRY_COUNT_W'(fill);
         r.empty = (fill == 0);
         awaited.push_back(r);
      endfunction

      function void check_response(kv_result_t got);
         kv_result_t want;
         if (awaited.size() == 0) begin
            $display("%0t: response with no request pending: status %0d value %h count %0d empty %0d",
                     $time, got.status, got.value, got.count, got.empty);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.value !== want.value) begin
            $display("%0t: value_out expected %h got %h", $time, want.value, got.value);
            errors++;
         end
         if (got.count !== want.count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want.count, got.count);
            errors++;
         end
         if (got.empty !== want.empty) begin
            $display("%0t: is_empty expected %0d got %0d", $time, want.empty, got.empty);
            errors++;
         end
      endfunction
   endclass
endpackage

module tb_linear_key_value_table_core;
   import lkv_pkg::*;
   import tb_lkv_scoreboard_pkg::*;

   localparam int RANDOM_REQUESTS = 750;
   localparam int QUIET_TAIL      = 120;
   localparam int KEY_POOL        = 24;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 400000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [REQ_TYPE_W-1:0]    req_type = REQ_LOOKUP;
   logic [KEY_W-1:0]         req_key = '0;
   logic [VALUE_W-1:0]       req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [VALUE_W-1:0]       rsp_value_out;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;
   logic                     rsp_is_empty;

   kv_table_scoreboard tracker = new();
   logic [KEY_W-1:0]   key_pool [KEY_POOL];
   bit                 quiet = 1'b0;
   int                 stall_left = 0;
   int                 cycle_count = 0;

   linear_key_value_table_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // random response back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_response(kv_result_t'{status: rsp_status, value: rsp_value_out,
                                             count: rsp_entry_count, empty: rsp_is_empty});
   end

   // present one request and hold it until accepted
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind, input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_key   <= k;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(kind, k, v);
   endtask

   initial begin
      int bias;
      int roll;
      int ins_pct;
      int rem_pct;
      logic [REQ_TYPE_W-1:0] kind;
      logic [KEY_W-1:0] k;

      bias = 0;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, extreme keys and values, duplicates
      send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_INSERT, 32'h0000_0000, 32'h1234_5678);
      // fill up, then full and duplicate-at-full inserts
      for (int i = 2; i < TABLE_DEPTH; i++)
         send_request(REQ_INSERT, 32'hC0DE_0000 | i, ~(32'hC0DE_0000 | i));
      send_request(REQ_INSERT, 32'h5A5A_A5A5, 32'h0F0F_F0F0);
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
      send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      // first slot removed, then the entry that moved into it
      send_request(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_request(REQ_REMOVE, 32'hC0DE_0000 | (TABLE_DEPTH - 1), 32'h0000_0000);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 50 == 0) bias = $urandom_range(0, 2);
         quiet = (n >= RANDOM_REQUESTS - QUIET_TAIL);
         // phases that lean toward filling, draining, or neither
         ins_pct = (bias == 0) ? 65 : (bias == 1) ? 20 : 40;
         rem_pct = (bias == 0) ? 15 : (bias == 1) ? 55 : 30;
         roll = $urandom_range(0, 99);
         if (roll < 4) kind = REQ_UNUSED;
         else if (roll < 4 + ins_pct) kind = REQ_INSERT;
         else if (roll < 4 + ins_pct + rem_pct) kind = REQ_REMOVE;
         else kind = REQ_LOOKUP;
         k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, KEY_POOL - 1)];
         send_request(kind, k, $urandom());
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
